// File: src/tpa_pkg.sv
`timescale 1ns / 1ps

package tpa_pkg;

    // ring of pulse timestamps
    localparam int NUM_STAMPS = 5;
    localparam int SLOT_W     = $clog2(NUM_STAMPS);
    localparam int IDX_W      = $clog2(NUM_STAMPS + 1);

    // field widths
    localparam int FUNC_W  = 2;
    localparam int TIME_W  = 32;
    localparam int FREQ_W  = 20;
    localparam int RPM_W   = 30;
    localparam int RPP_W   = 10;
    localparam int PCNT_W  = 16;
    localparam int CFG_IDX_W = 2;

    // delta sum and serial divider sizing
    localparam int SUM_W     = TIME_W + SLOT_W;
    localparam int ITER_W    = $clog2(SUM_W + 1);
    localparam int MUL_CNT_W = $clog2(RPP_W + 1);

    localparam logic [FREQ_W-1:0] FREQ_NUM   = FREQ_W'(1000000);
    localparam logic [PCNT_W-1:0] PCNT_MAX   = '1;
    localparam logic [RPP_W-1:0]  RPP_RST    = RPP_W'(60);
    localparam logic [TIME_W-1:0] STALE_RST  = TIME_W'(1000000);
    localparam logic [TIME_W-1:0] GLITCH_RST = TIME_W'(10000000);

    // func codes
    localparam logic [FUNC_W-1:0] FUNC_PULSE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TALLY = 2'd2;

    // result kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_TALLY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_PER_PULSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_DEFAULT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_LIMIT  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STALE,
        ST_WALK,
        ST_AVG_CHK,
        ST_DIV1,
        ST_DIV2,
        ST_HOLD,
        ST_MUL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [ITER_W-1:0] iters;
        logic [SUM_W-1:0]  dividend;
        logic [FREQ_W-1:0] divisor;
    } t_div_cmd;

endpackage

// File: src/tpa_intf.sv
`timescale 1ns / 1ps

interface tpa_in_if import tpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [TIME_W-1:0] time_us;

    modport source (output valid, output func, output time_us, input ready);
    modport sink   (input valid, input func, input time_us, output ready);
endinterface

interface tpa_out_if import tpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [FREQ_W-1:0] freq_hz;
    logic [RPM_W-1:0]  rpm;
    logic [PCNT_W-1:0] pulse_count;

    modport source (output valid, output kind, output freq_hz, output rpm,
                    output pulse_count, input ready);
    modport sink   (input valid, input kind, input freq_hz, input rpm,
                    input pulse_count, output ready);
endinterface

// File: src/tach_period_averager.sv
`timescale 1ns / 1ps

// channel  | dir | payload                              | handshake
// i_in     | in  | func[1:0], time_us[31:0]             | valid/ready
// o_out    | out | kind, freq_hz[19:0], rpm[29:0],      | valid/ready
//          |     | pulse_count[15:0]                    |
// i_cfg_*  | in  | i_cfg_idx[1:0], i_cfg_data[31:0]     | i_cfg_we, no wait
//
// a pulse is taken in the idle state, a tally passes through the emit state; a read
// walks the stamp ring, divides and multiplies, after a stale check (which can end it)
// when no pulse came since the last read; the length of a read is
// set mostly by the serial divider that yields one quotient bit per cycle.
// synchronous active-low reset; the stamp ring has per-entry valid bits, no sweep.
// input is taken only while idle; a finished result waits in the output register
// while the next transaction is taken.
module tach_period_averager import tpa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tpa_in_if.sink               i_in,
    tpa_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TIME_W-1:0]    i_cfg_data
);

    t_state            r_state;
    t_state            n_state;

    // configuration
    logic [RPP_W-1:0]  r_rpp;
    logic [TIME_W-1:0] r_stale_def;
    logic [TIME_W-1:0] r_glitch;

    // tachometer state
    logic [SLOT_W-1:0] r_wslot;
    logic [SLOT_W-1:0] r_lslot;
    logic [TIME_W-1:0] r_thresh;
    logic [FREQ_W-1:0] r_held;
    logic [PCNT_W-1:0] r_pcnt;

    // read working registers
    logic [TIME_W-1:0] r_now;
    logic [IDX_W-1:0]  r_idx;
    logic [TIME_W-1:0] r_prev;
    logic [SUM_W-1:0]  r_sum;
    logic [SLOT_W-1:0] r_n;
    logic [FREQ_W-1:0] r_fresh;
    logic [RPM_W-1:0]  r_prod;
    logic              r_pend_kind;
    logic [PCNT_W-1:0] r_pend_cnt;

    // output register
    logic              r_out_valid;
    logic              r_o_kind;
    logic [FREQ_W-1:0] r_o_freq;
    logic [RPM_W-1:0]  r_o_rpm;
    logic [PCNT_W-1:0] r_o_cnt;

    logic              w_in_acc;
    logic              w_out_free;
    logic              w_ring_we;
    logic              w_ring_re;
    logic [SLOT_W-1:0] w_ring_raddr;
    logic [TIME_W-1:0] w_rdata;
    logic [TIME_W-1:0] w_elapsed;
    logic [TIME_W-1:0] w_delta;
    logic              w_stale;
    logic              w_avg_zero;
    t_div_cmd          w_div_cmd;
    logic              w_div_done;
    logic [SUM_W-1:0]  w_quot;
    logic              w_mul_start;
    logic              w_mul_done;
    logic [RPM_W-1:0]  w_prod;
    logic [FREQ_W-1:0] w_held_new;

    assign w_in_acc   = i_in.valid & i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_ring_we  = w_in_acc && (i_in.func == FUNC_PULSE);
    assign w_elapsed  = r_now - w_rdata;
    assign w_delta    = w_rdata - r_prev;
    assign w_stale    = (w_elapsed > r_thresh);
    assign w_avg_zero = (w_quot == '0) || (w_quot > SUM_W'(FREQ_NUM));

    // within one of the held value keeps the larger
    assign w_held_new = ({1'b0, r_held} == ({1'b0, r_fresh} + (FREQ_W+1)'(1)))
                        ? r_held : r_fresh;

    tpa_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_ring_we),
        .i_waddr (r_wslot),
        .i_wdata (i_in.time_us),
        .i_re    (w_ring_re),
        .i_raddr (w_ring_raddr),
        .o_rdata (w_rdata)
    );

    tpa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_div_cmd),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    tpa_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_mcand  (w_held_new),
        .i_mplier (r_rpp),
        .o_done   (w_mul_done),
        .o_prod   (w_prod)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (i_in.func)
                        FUNC_READ:  n_state = (r_wslot == r_lslot) ? ST_STALE : ST_WALK;
                        FUNC_TALLY: n_state = ST_EMIT;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_STALE:   n_state = w_stale ? ST_EMIT : ST_WALK;
            ST_WALK: begin
                if (r_idx == IDX_W'(NUM_STAMPS)) begin
                    n_state = ST_AVG_CHK;
                end
            end
            ST_AVG_CHK: n_state = (r_n == '0) ? ST_EMIT : ST_DIV1;
            ST_DIV1: begin
                if (w_div_done) begin
                    n_state = w_avg_zero ? ST_HOLD : ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (w_div_done) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD:    n_state = ST_MUL;
            ST_MUL: begin
                if (w_mul_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_in.ready         = 1'b0;
        w_ring_re          = 1'b0;
        w_ring_raddr       = r_lslot;
        w_div_cmd.start    = 1'b0;
        w_div_cmd.iters    = ITER_W'(SUM_W);
        w_div_cmd.dividend = r_sum;
        w_div_cmd.divisor  = FREQ_W'(r_n);
        w_mul_start        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                w_ring_re  = i_in.valid && (i_in.func == FUNC_READ);
            end
            ST_WALK: begin
                w_ring_re    = (r_idx < IDX_W'(NUM_STAMPS));
                w_ring_raddr = r_idx[SLOT_W-1:0];
            end
            ST_AVG_CHK: begin
                w_div_cmd.start = (r_n != '0);
            end
            ST_DIV1: begin
                // reciprocal: numerator left-aligned, one bit per frequency bit
                w_div_cmd.start    = w_div_done && !w_avg_zero;
                w_div_cmd.iters    = ITER_W'(FREQ_W);
                w_div_cmd.dividend = SUM_W'(FREQ_NUM) << (SUM_W - FREQ_W);
                w_div_cmd.divisor  = w_quot[FREQ_W-1:0];
            end
            ST_HOLD: begin
                w_mul_start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rpp       <= RPP_RST;
            r_stale_def <= STALE_RST;
            r_glitch    <= GLITCH_RST;
            r_wslot     <= '0;
            r_lslot     <= '0;
            r_thresh    <= STALE_RST;
            r_held      <= '0;
            r_pcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RPM_PER_PULSE: r_rpp       <= i_cfg_data[RPP_W-1:0];
                    CFG_STALE_DEFAULT: r_stale_def <= i_cfg_data;
                    CFG_GLITCH_LIMIT:  r_glitch    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if ((r_state == ST_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        case (i_in.func)
                            FUNC_PULSE: begin
                                r_wslot <= (r_wslot == SLOT_W'(NUM_STAMPS - 1))
                                           ? '0 : r_wslot + SLOT_W'(1);
                                if (r_pcnt != PCNT_MAX) begin
                                    r_pcnt <= r_pcnt + PCNT_W'(1);
                                end
                            end
                            FUNC_READ: begin
                                r_lslot <= r_wslot;
                            end
                            FUNC_TALLY: begin
                                r_pcnt <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_STALE: begin
                    if (w_stale) begin
                        r_thresh <= w_elapsed;
                        r_held   <= '0;
                    end else begin
                        r_thresh <= r_stale_def;
                    end
                end
                ST_AVG_CHK: begin
                    if (r_n == '0) begin
                        r_held <= '0;
                    end
                end
                ST_HOLD: begin
                    r_held <= w_held_new;
                end
                default: begin
                end
            endcase
        end
    end

    // read datapath and output payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_now       <= i_in.time_us;
                r_idx       <= '0;
                r_sum       <= '0;
                r_n         <= '0;
                r_prod      <= '0;
                r_pend_kind <= (i_in.func == FUNC_TALLY) ? KIND_TALLY : KIND_READ;
                r_pend_cnt  <= r_pcnt;
            end
            ST_WALK: begin
                r_idx <= r_idx + IDX_W'(1);
                if (r_idx != '0) begin
                    r_prev <= w_rdata;
                end
                // first stamp only seeds the previous value
                if ((r_idx >= IDX_W'(2)) && (w_delta <= r_glitch)) begin
                    r_sum <= r_sum + SUM_W'(w_delta);
                    r_n   <= r_n + SLOT_W'(1);
                end
            end
            ST_DIV1: begin
                if (w_div_done && w_avg_zero) begin
                    r_fresh <= '0;
                end
            end
            ST_DIV2: begin
                if (w_div_done) begin
                    r_fresh <= w_quot[FREQ_W-1:0];
                end
            end
            ST_MUL: begin
                if (w_mul_done) begin
                    r_prod <= w_prod;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    r_o_kind <= r_pend_kind;
                    if (r_pend_kind == KIND_TALLY) begin
                        r_o_freq <= '0;
                        r_o_rpm  <= '0;
                        r_o_cnt  <= r_pend_cnt;
                    end else begin
                        r_o_freq <= r_held;
                        r_o_rpm  <= r_prod;
                        r_o_cnt  <= '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_o_kind;
    assign o_out.freq_hz     = r_o_freq;
    assign o_out.rpm         = r_o_rpm;
    assign o_out.pulse_count = r_o_cnt;

endmodule

// File: src/tpa_ring.sv
`timescale 1ns / 1ps

module tpa_ring import tpa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [SLOT_W-1:0] i_waddr,
    input  logic [TIME_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [SLOT_W-1:0] i_raddr,
    output logic [TIME_W-1:0] o_rdata
);

    logic [TIME_W-1:0]     r_mem [NUM_STAMPS];
    logic [NUM_STAMPS-1:0] r_vld;
    logic [TIME_W-1:0]     r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // an entry never written reads as zero
        if (i_re) begin
            r_rdata <= r_vld[i_raddr] ? r_mem[i_raddr] : '0;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/tpa_div.sv
`timescale 1ns / 1ps

module tpa_div import tpa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_cmd         i_cmd,
    output logic             o_done,
    output logic [SUM_W-1:0] o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [ITER_W-1:0] r_cnt;
    logic [SUM_W-1:0]  r_dvd;
    logic [FREQ_W-1:0] r_dsr;
    logic [FREQ_W-1:0] r_rem;
    logic [SUM_W-1:0]  r_quot;

    logic [FREQ_W:0]   w_trial;
    logic              w_ge;
    logic [FREQ_W:0]   w_rem_n;

    // restoring division, one quotient bit per cycle
    assign w_trial = {r_rem, r_dvd[SUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dsr});
    assign w_rem_n = w_ge ? (w_trial - {1'b0, r_dsr}) : w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - ITER_W'(1);
                if (r_cnt == ITER_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_dvd  <= i_cmd.dividend;
            r_dsr  <= i_cmd.divisor;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[SUM_W-2:0], 1'b0};
            r_rem  <= w_rem_n[FREQ_W-1:0];
            r_quot <= {r_quot[SUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: src/tpa_mul.sv
`timescale 1ns / 1ps

module tpa_mul import tpa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [FREQ_W-1:0] i_mcand,
    input  logic [RPP_W-1:0]  i_mplier,
    output logic              o_done,
    output logic [RPM_W-1:0]  o_prod
);

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [RPM_W-1:0]     r_mcand;
    logic [RPP_W-1:0]     r_mplier;
    logic [RPM_W-1:0]     r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= MUL_CNT_W'(RPP_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - MUL_CNT_W'(1);
                if (r_cnt == MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift-add, one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= RPM_W'(i_mcand);
            r_mplier <= i_mplier;
            r_acc    <= '0;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[RPM_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[RPP_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// File: tb/tb_tach_period_averager.sv
`timescale 1ns / 1ps

module tb_tach_period_averager;
    import tpa_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 200;
    localparam int DIR_ROWS      = 23;

    localparam longint unsigned US_PER_SEC = 1000000;

    typedef struct packed {
        logic              kind;
        logic [FREQ_W-1:0] freq_hz;
        logic [RPM_W-1:0]  rpm;
        logic [PCNT_W-1:0] pulse_count;
    } t_reading;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [TIME_W-1:0] time_us;
        logic              typed;
        t_reading          want;
    } t_dir_row;

    localparam t_reading READ_ZERO  = '0;
    localparam t_reading TALLY_NONE = '{kind: KIND_TALLY, default: '0};
    localparam t_reading TALLY_FIVE = '{kind: KIND_TALLY, freq_hz: '0, rpm: '0,
                                        pulse_count: 16'd5};

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [TIME_W-1:0]  cfg_data;

    tpa_in_if  in_ch ();
    tpa_out_if out_ch ();

    tach_period_averager uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // tachometer state as the block should hold it
    logic [TIME_W-1:0] ring_stamp [NUM_STAMPS];
    logic [SLOT_W-1:0] head_slot;
    logic [SLOT_W-1:0] read_mark;
    logic [TIME_W-1:0] silence_limit;
    logic [FREQ_W-1:0] shown_hz;
    logic [PCNT_W-1:0] pulse_tally;
    logic [RPP_W-1:0]  rpm_mult;
    logic [TIME_W-1:0] silence_default;
    logic [TIME_W-1:0] glitch_cap;

    t_reading pending_readings [$];
    t_reading want;
    int       errors;
    int       idle_cycles;
    bit       steady;
    logic [TIME_W-1:0] now_us;
    logic [TIME_W-1:0] period_us;

    // directed stimulus; typed rows carry their result, the rest use the predictor
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{FUNC_TALLY,  32'd0,          1'b1, TALLY_NONE},
        '{FUNC_READ,   32'hFFFF_FFFF,  1'b1, READ_ZERO},   // stale right after reset
        '{FUNC_READ,   32'd5,          1'b1, READ_ZERO},   // all deltas zero
        '{FUNC_UNUSED, 32'd123,        1'b0, READ_ZERO},
        '{FUNC_PULSE,  32'd1000,       1'b0, READ_ZERO},
        '{FUNC_PULSE,  32'd2000,       1'b0, READ_ZERO},
        '{FUNC_PULSE,  32'd3000,       1'b0, READ_ZERO},
        '{FUNC_PULSE,  32'd4000,       1'b0, READ_ZERO},
        '{FUNC_PULSE,  32'd5000,       1'b0, READ_ZERO},
        '{FUNC_READ,   32'd5500,       1'b0, READ_ZERO},
        '{FUNC_TALLY,  32'd5600,       1'b1, TALLY_FIVE},
        '{FUNC_PULSE,  32'd6001,       1'b0, READ_ZERO},   // backward delta is a glitch
        '{FUNC_READ,   32'd6100,       1'b0, READ_ZERO},
        '{FUNC_READ,   32'd1100000,    1'b0, READ_ZERO},   // long silence
        '{FUNC_PULSE,  32'hFFFF_FFFE,  1'b0, READ_ZERO},
        '{FUNC_PULSE,  32'hFFFF_FFFF,  1'b0, READ_ZERO},
        '{FUNC_PULSE,  32'd0,          1'b0, READ_ZERO},   // time wraps
        '{FUNC_PULSE,  32'd1,          1'b0, READ_ZERO},
        '{FUNC_PULSE,  32'd2,          1'b0, READ_ZERO},
        '{FUNC_READ,   32'd3,          1'b0, READ_ZERO},   // one microsecond period
        '{FUNC_PULSE,  32'd2,          1'b0, READ_ZERO},
        '{FUNC_READ,   32'd10,         1'b0, READ_ZERO},
        '{FUNC_TALLY,  32'd11,         1'b0, READ_ZERO}
    };

    task automatic tach_reset_model();
        for (int i = 0; i < NUM_STAMPS; i++) begin
            ring_stamp[i] = '0;
        end
        head_slot       = '0;
        read_mark       = '0;
        silence_limit   = STALE_RST;
        shown_hz        = '0;
        pulse_tally     = '0;
        rpm_mult        = RPP_RST;
        silence_default = STALE_RST;
        glitch_cap      = GLITCH_RST;
    endtask

    function automatic bit tach_predict(input logic [FUNC_W-1:0] func,
                                        input logic [TIME_W-1:0] t,
                                        output t_reading res);
        logic [TIME_W-1:0] gap_us;
        longint unsigned   span_sum;
        longint unsigned   mean_us;
        int unsigned       used;
        int unsigned       fresh_hz;
        int unsigned       step;
        res = '0;
        case (func)
            FUNC_PULSE: begin
                ring_stamp[head_slot] = t;
                head_slot = (head_slot == SLOT_W'(NUM_STAMPS - 1)) ? '0 : head_slot + 1'b1;
                if (pulse_tally != PCNT_MAX) pulse_tally = pulse_tally + 1'b1;
                return 1'b0;
            end
            FUNC_TALLY: begin
                res.kind        = KIND_TALLY;
                res.pulse_count = pulse_tally;
                pulse_tally     = '0;
                return 1'b1;
            end
            FUNC_READ: begin
                res.kind = KIND_READ;
                // no pulse since the last read: check for a stalled input
                if (head_slot == read_mark) begin
                    gap_us = t - ring_stamp[read_mark];
                    if (gap_us > silence_limit) begin
                        silence_limit = gap_us;
                        shown_hz      = '0;
                        return 1'b1;
                    end
                    silence_limit = silence_default;
                end
                read_mark = head_slot;
                span_sum  = 0;
                used      = 0;
                for (int i = 1; i < NUM_STAMPS; i++) begin
                    gap_us = ring_stamp[i] - ring_stamp[i-1];
                    if (gap_us <= glitch_cap) begin
                        span_sum += gap_us;
                        used++;
                    end
                end
                if (used == 0) begin
                    shown_hz = '0;
                    return 1'b1;
                end
                mean_us  = span_sum / used;
                fresh_hz = (mean_us == 0) ? 0 : 32'(US_PER_SEC / mean_us);
                step     = (fresh_hz > shown_hz) ? fresh_hz - shown_hz : shown_hz - fresh_hz;
                // within one of the held value keeps the larger
                if (step > 1 || fresh_hz > shown_hz) shown_hz = FREQ_W'(fresh_hz);
                res.freq_hz = shown_hz;
                res.rpm     = RPM_W'(64'(shown_hz) * 64'(rpm_mult));
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [TIME_W-1:0] t,
                             input bit typed, input t_reading typed_want);
        int       gap;
        bit       yields;
        t_reading got;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.func    = func;
        in_ch.time_us = t;
        do @(posedge i_clk); while (!in_ch.ready);
        yields = tach_predict(func, t, got);
        if (yields) pending_readings.push_back(typed ? typed_want : got);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid = 1'b0;
        while (pending_readings.size() != 0) @(negedge i_clk);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_RPM_PER_PULSE: rpm_mult        = RPP_W'(data);
            CFG_STALE_DEFAULT: silence_default = data;
            CFG_GLITCH_LIMIT:  glitch_cap      = data;
            default: ;
        endcase
    endtask

    // pulse trains with random period and jitter, reads, tallies and some noise
    task automatic run_phase(input int n_items);
        int k;
        int r;
        k = 0;
        while (k < n_items) begin
            if ($urandom_range(0, 39) == 0) begin
                case ($urandom_range(0, 3))
                    0: period_us = $urandom_range(1, 20);
                    1: period_us = $urandom_range(20, 5000);
                    2: period_us = $urandom_range(5000, 300000);
                    default: period_us = $urandom;
                endcase
            end
            if ($urandom_range(0, 149) == 0) drain();
            r = $urandom_range(0, 99);
            if (r < 58) begin
                if ($urandom_range(0, 29) == 0) begin
                    now_us += $urandom;
                end else if ($urandom_range(0, 29) != 0) begin
                    now_us += period_us + $urandom_range(0, period_us >> 4);
                end
                send_item(FUNC_PULSE, now_us, 1'b0, READ_ZERO);
                k++;
            end else if (r < 80) begin
                now_us += $urandom_range(0, period_us);
                send_item(FUNC_READ, now_us, 1'b0, READ_ZERO);
                k++;
            end else if (r < 85) begin
                // silence that may be long enough to look stalled
                if ($urandom_range(0, 3) == 0) now_us += $urandom;
                else now_us += $urandom_range(0, 4000000);
                send_item(FUNC_READ, now_us, 1'b0, READ_ZERO);
                k++;
            end else if (r < 93) begin
                send_item(FUNC_TALLY, now_us, 1'b0, READ_ZERO);
                k++;
            end else if (r < 96) begin
                send_item(FUNC_W'($urandom_range(0, 2)), $urandom, 1'b0, READ_ZERO);
                k++;
            end else begin
                send_item(FUNC_UNUSED, $urandom, 1'b0, READ_ZERO);
            end
        end
    endtask

    // result side back-pressure
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            int stall;
            @(negedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_readings.size() == 0) begin
                $error("result with no pending transaction: kind %0d freq_hz %0d",
                       out_ch.kind, out_ch.freq_hz);
                errors++;
            end else begin
                want = pending_readings.pop_front();
                if (out_ch.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
                    errors++;
                end
                if (out_ch.freq_hz !== want.freq_hz) begin
                    $error("freq_hz: expected %0d, got %0d", want.freq_hz, out_ch.freq_hz);
                    errors++;
                end
                if (out_ch.rpm !== want.rpm) begin
                    $error("rpm: expected %0d, got %0d", want.rpm, out_ch.rpm);
                    errors++;
                end
                if (out_ch.pulse_count !== want.pulse_count) begin
                    $error("pulse_count: expected %0d, got %0d",
                           want.pulse_count, out_ch.pulse_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [RPP_W-1:0]  set_rpp;
        logic [TIME_W-1:0] set_stale;
        logic [TIME_W-1:0] set_glitch;
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_RPM_PER_PULSE;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.func    = FUNC_PULSE;
        in_ch.time_us = '0;
        steady        = 1'b0;
        errors        = 0;
        idle_cycles   = 0;
        period_us     = 32'd1000;
        tach_reset_model();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_item(dir_rows[i].func, dir_rows[i].time_us, dir_rows[i].typed,
                      dir_rows[i].want);
        end

        now_us = $urandom;
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: begin
                    set_rpp = '1; set_stale = '0; set_glitch = '1;
                end
                1: begin
                    set_rpp = '0; set_stale = '1; set_glitch = '0;
                end
                2: begin
                    set_rpp = RPP_RST; set_stale = STALE_RST; set_glitch = GLITCH_RST;
                end
                3: begin
                    set_rpp = '1; set_stale = 32'd2000; set_glitch = 32'd5000;
                end
                default: begin
                    set_rpp    = RPP_W'($urandom_range(0, 1023));
                    set_stale  = (ph == 6) ? $urandom : $urandom_range(0, 3000000);
                    set_glitch = (ph == 7) ? $urandom : $urandom_range(1000, 20000000);
                end
            endcase
            cfg_write(CFG_RPM_PER_PULSE, TIME_W'(set_rpp));
            cfg_write(CFG_STALE_DEFAULT, set_stale);
            cfg_write(CFG_GLITCH_LIMIT, set_glitch);
            steady = (ph == 3);
            run_phase(PHASE_ITEMS);
        end
        steady = 1'b0;
        settle();

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
